>>> rtl/core/qetok_pkg.sv
// Shared types, result codes and the character classifier of the quoted tokenizer.
package qetok_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_OK   = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // Request types
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_EOL  = 1'b1;

  // Results one request can cause
  localparam int MaxResults = 2;
  // Output queue depth
  localparam int QueueDepth = 4;

  typedef enum logic [2:0] {
    CLS_UNK,
    CLS_WS,
    CLS_BSL,
    CLS_QUOTE,
    CLS_DIGIT,
    CLS_ALPHA,
    CLS_SYM
  } cls_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  // Results of one request, count first
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Classify one character byte
  function automatic cls_t classify(input logic [7:0] ch);
    cls_t c;
    c = CLS_UNK;
    unique case (ch)
      8'd32, 8'd9, 8'd10, 8'd13: c = CLS_WS;
      8'd92:                     c = CLS_BSL;
      8'd34:                     c = CLS_QUOTE;
      // ~ ! @ # $ % ^ & * ( ) _ - + = { } [ ] | ' : ; < , > . ? /
      8'd126, 8'd33, 8'd64, 8'd35, 8'd36, 8'd37, 8'd94, 8'd38, 8'd42,
      8'd40, 8'd41, 8'd95, 8'd45, 8'd43, 8'd61, 8'd123, 8'd125, 8'd91,
      8'd93, 8'd124, 8'd39, 8'd58, 8'd59, 8'd60, 8'd44, 8'd62, 8'd46,
      8'd63, 8'd47:              c = CLS_SYM;
      default: begin
        if (ch >= 8'd48 && ch <= 8'd57) begin
          c = CLS_DIGIT;
        end else if ((ch >= 8'd65 && ch <= 8'd90) || (ch >= 8'd97 && ch <= 8'd122)) begin
          c = CLS_ALPHA;
        end else begin
          c = CLS_UNK;
        end
      end
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/quoted_escape_tokenizer_unit.sv
// Top level of the quoted, escaped tokenizer.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   req_type, char_byte
//   out      output     out_valid / out_ready out_kind, out_byte, last_of_run
//
// One request is accepted per cycle while in_ready is high; its zero, one or two results
// enter a four-entry result queue at the accepting edge; the first can leave at the next
// edge. The queue drains one result per cycle while out_ready is high, so a stream of
// two-result requests is held back by in_ready; requests of at most one result need not stall.
// in_ready drops while the queue lacks room for two results.
// Synchronous reset puts the parser between tokens and empties the queue.
module quoted_escape_tokenizer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] char_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  qetok_pkg::push_t push;
  qetok_pkg::res_t  head;
  logic             take;

  assign take = in_valid && in_ready;

  // Parse the accepted request
  qetok_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .req_type  (req_type),
    .char_byte (char_byte),
    .push      (push)
  );

  // Queue results toward the output
  qetok_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (in_ready),
    .head_valid (out_valid),
    .head_take  (out_ready),
    .head       (head)
  );

  assign out_kind    = head.kind;
  assign out_byte    = head.data;
  assign last_of_run = head.last;

endmodule

>>> rtl/core/qetok_parse.sv
// Parser state and the single-pass step that turns one request into its results.
module qetok_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic               req_type,
  input  logic [7:0]         char_byte,
  output qetok_pkg::push_t   push
);

  typedef enum logic [3:0] {
    M_BETWEEN,
    M_UNQ,
    M_ESC_U,
    M_OCT_U1,
    M_OCT_U2,
    M_QUO,
    M_ESC_Q,
    M_OCT_Q1,
    M_OCT_Q2,
    M_DROP
  } mode_t;

  mode_t       mode, mode_next;
  logic [5:0]  oct, oct_next;
  logic        thb, thb_next;

  qetok_pkg::cls_t cls;
  logic        is_oct;
  logic        quoted;
  mode_t       back;
  logic        do_fail;
  logic        do_emit;
  logic [7:0]  emit_val;
  logic [1:0]  line_kind;
  qetok_pkg::push_t res;

  assign cls    = qetok_pkg::classify(char_byte);
  assign is_oct = (cls == qetok_pkg::CLS_DIGIT) && (char_byte <= 8'd55);
  assign quoted = (mode == M_QUO) || (mode == M_ESC_Q) || (mode == M_OCT_Q1) ||
                  (mode == M_OCT_Q2);
  assign back   = quoted ? M_QUO : M_UNQ;
  assign line_kind = (mode == M_BETWEEN || mode == M_UNQ) ? qetok_pkg::KIND_OK
                                                          : qetok_pkg::KIND_ERR;

  // Step one request through the parser
  always_comb begin
    mode_next = mode;
    oct_next  = oct;
    thb_next  = thb;
    do_fail   = 1'b0;
    do_emit   = 1'b0;
    emit_val  = char_byte;
    res       = '0;

    if (req_type == qetok_pkg::REQ_EOL) begin
      // Close the line: flush the token, then report status (nothing while dropping)
      if (mode != M_DROP) begin
        if (thb) begin
          res.r0.kind = qetok_pkg::KIND_END;
          res.r1.kind = line_kind;
          res.count   = 2'd2;
        end else begin
          res.r0.kind = line_kind;
          res.count   = 2'd1;
        end
      end
      mode_next = M_BETWEEN;
      oct_next  = '0;
      thb_next  = 1'b0;
    end else begin
      unique case (mode)
        M_DROP: begin
        end
        M_UNQ, M_QUO: begin
          if (cls == qetok_pkg::CLS_UNK || (cls == qetok_pkg::CLS_QUOTE && !quoted)) begin
            do_fail = 1'b1;
          end else if (cls == qetok_pkg::CLS_WS && !quoted) begin
            if (thb) begin
              res.r0.kind = qetok_pkg::KIND_END;
              res.count   = 2'd1;
            end
            thb_next  = 1'b0;
            mode_next = M_BETWEEN;
          end else if (cls == qetok_pkg::CLS_BSL) begin
            mode_next = quoted ? M_ESC_Q : M_ESC_U;
          end else if (cls == qetok_pkg::CLS_QUOTE) begin
            // Closing quote always marks the end, even for an empty token
            res.r0.kind = qetok_pkg::KIND_END;
            res.count   = 2'd1;
            thb_next    = 1'b0;
            mode_next   = M_BETWEEN;
          end else begin
            do_emit = 1'b1;
          end
        end
        M_ESC_U, M_ESC_Q: begin
          if (cls == qetok_pkg::CLS_BSL || cls == qetok_pkg::CLS_QUOTE ||
              cls == qetok_pkg::CLS_SYM) begin
            do_emit   = 1'b1;
            mode_next = back;
          end else if (is_oct) begin
            oct_next  = {3'b000, char_byte[2:0]};
            mode_next = quoted ? M_OCT_Q1 : M_OCT_U1;
          end else if (char_byte == 8'd110 || char_byte == 8'd114) begin
            do_emit   = 1'b1;
            emit_val  = (char_byte == 8'd110) ? 8'd10 : 8'd13;
            mode_next = back;
          end else begin
            do_fail = 1'b1;
          end
        end
        M_OCT_U1, M_OCT_Q1: begin
          if (is_oct) begin
            oct_next  = {oct[2:0], char_byte[2:0]};
            mode_next = quoted ? M_OCT_Q2 : M_OCT_U2;
          end else begin
            do_fail = 1'b1;
          end
        end
        M_OCT_U2, M_OCT_Q2: begin
          if (is_oct) begin
            do_emit   = 1'b1;
            emit_val  = {oct[4:0], char_byte[2:0]};
            oct_next  = '0;
            mode_next = back;
          end else begin
            do_fail = 1'b1;
          end
        end
        default: begin
          // Between tokens
          mode_next = M_BETWEEN;
          if (cls == qetok_pkg::CLS_UNK) begin
            do_fail = 1'b1;
          end else if (cls == qetok_pkg::CLS_WS) begin
            mode_next = M_BETWEEN;
          end else if (cls == qetok_pkg::CLS_BSL) begin
            mode_next = M_ESC_U;
          end else if (cls == qetok_pkg::CLS_QUOTE) begin
            mode_next = M_QUO;
          end else begin
            do_emit   = 1'b1;
            mode_next = M_UNQ;
          end
        end
      endcase

      // Emit one token byte
      if (do_emit) begin
        res.r0.kind = qetok_pkg::KIND_BYTE;
        res.r0.data = emit_val;
        res.count   = 2'd1;
        thb_next    = 1'b1;
      end

      // Flush the token, report the error, drop until end of line
      if (do_fail) begin
        if (thb) begin
          res.r0.kind = qetok_pkg::KIND_END;
          res.r1.kind = qetok_pkg::KIND_ERR;
          res.count   = 2'd2;
        end else begin
          res.r0.kind = qetok_pkg::KIND_ERR;
          res.count   = 2'd1;
        end
        thb_next  = 1'b0;
        mode_next = M_DROP;
        oct_next  = '0;
      end
    end

    // Mark the last result of the request
    if (res.count == 2'd1) begin
      res.r0.last = 1'b1;
    end else if (res.count == 2'd2) begin
      res.r1.last = 1'b1;
    end

    push = res;
    if (!take) begin
      push.count = 2'd0;
    end
  end

  // Hold parser state, advance on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_BETWEEN;
      oct  <= '0;
      thb  <= 1'b0;
    end else if (take) begin
      mode <= mode_next;
      oct  <= oct_next;
      thb  <= thb_next;
    end
  end

endmodule

>>> rtl/core/qetok_outq.sv
// Short result queue: takes up to two results a cycle, hands out one from its head.
module qetok_outq (
  input  logic               clk,
  input  logic               rst,
  input  qetok_pkg::push_t   push,
  output logic               room,
  output logic               head_valid,
  input  logic               head_take,
  output qetok_pkg::res_t    head
);

  localparam int CntW = $clog2(qetok_pkg::QueueDepth + 1);

  qetok_pkg::res_t q [qetok_pkg::QueueDepth];
  qetok_pkg::res_t q_next [qetok_pkg::QueueDepth];
  logic [CntW-1:0] count, count_next, base;
  logic            pop;

  assign pop        = head_valid && head_take;
  assign head_valid = (count != '0);
  assign room       = (count <= CntW'(qetok_pkg::QueueDepth - qetok_pkg::MaxResults));
  assign head       = q[0];
  assign base       = count - CntW'(pop);

  // Shift out the head, then place new results behind what remains
  always_comb begin
    for (int i = 0; i < qetok_pkg::QueueDepth; i++) begin
      if (pop && i < qetok_pkg::QueueDepth - 1) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
      if (push.count != 2'd0 && base == CntW'(i)) begin
        q_next[i] = push.r0;
      end
      if (push.count == 2'd2 && base + CntW'(1) == CntW'(i)) begin
        q_next[i] = push.r1;
      end
    end
    count_next = base + CntW'(push.count);
  end

  // Hold the count; entries need no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < qetok_pkg::QueueDepth; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule
